FILE: hdl/assert_macros.svh
// Assertion macros shared by the escape-time block.
// Each macro expands to one concurrent assertion in simulation and to nothing under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent in this cycle implies consequent in the next
`define MBET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define MBET_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define MBET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define MBET_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/mbet_pkg.sv
// Types, widths and constants of the escape-time block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbet_pkg;

  localparam int ITER_W    = 10;
  localparam int PIX_W     = 10;
  localparam int STEP_W    = 31;
  localparam int COORD_W   = 32;
  localparam int PROD_W    = 64;
  localparam int SAT_W     = 66;
  localparam int FRAC_BITS = 28;
  localparam int COLOR_W   = 24;
  localparam int DIV_NUM_W = ITER_W + 8;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam int unsigned ITER_LIMIT_MAX = 1023;

  localparam logic [COLOR_W-1:0] INSIDE_COLOR = 24'h808080;
  // 4.0 in Q8.56
  localparam logic [PROD_W:0]    ESCAPE_LIMIT = 65'h0_0400_0000_0000_0000;

  localparam logic [STEP_W-1:0]  PIXEL_STEP_RST  = 31'd1048576;
  localparam logic [COORD_W-1:0] ORIGIN_REAL_RST = 32'hE000_0000;
  localparam logic [COORD_W-1:0] ORIGIN_IMAG_RST = 32'hE800_0000;
  localparam logic [ITER_W-1:0]  ITER_CAP_RST    = 10'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_STEP  = 2'd0,
    CFG_ORIGIN_REAL = 2'd1,
    CFG_ORIGIN_IMAG = 2'd2,
    CFG_ITER_CAP    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic setup;
    logic mul;
    logic upd;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic in_set;
    logic div_done;
  } sts_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mbet_div.sv
// Restoring divider for the grey level: one quotient bit a cycle.
// Depends on mbet_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbet_div (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  [mbet_pkg::DIV_NUM_W-1:0]   num,
  input  wire  [mbet_pkg::ITER_W-1:0]      den,
  output logic                             done,
  output logic [mbet_pkg::DIV_NUM_W-1:0]   quo
);
  import mbet_pkg::*;

  logic                  busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0]  q_r, q_nxt;
  logic [ITER_W-1:0]     rem_r, rem_nxt;
  logic [ITER_W:0]       trial;
  logic                  ge;

  assign trial = {rem_r, q_r[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign done  = busy_r && (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1));
  assign quo   = q_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in one numerator bit, subtract when it fits
      rem_nxt = ge ? ITER_W'(trial - {1'b0, den}) : trial[ITER_W-1:0];
      q_nxt   = {q_r[DIV_NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  `MBET_ASSERT_NEXT(a_div_start_busy, clk, rst_n, start, busy_r)
  `MBET_ASSERT_NEXT(a_div_done_idle, clk, rst_n, done && !start, !busy_r)

endmodule

`default_nettype wire

FILE: hdl/mbet_dp.sv
// Datapath: configuration registers, coordinate setup, z = z*z + c iteration,
// grey-level division and output holding registers. Depends on mbet_pkg, mbet_div.
`default_nettype none

module mbet_dp (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [mbet_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire  [mbet_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire  [mbet_pkg::PIX_W-1:0]        pixel_x,
  input  wire  [mbet_pkg::PIX_W-1:0]        pixel_y,
  input  wire  mbet_pkg::cmd_t              cmd,
  output mbet_pkg::sts_t                    sts,
  output logic [mbet_pkg::PIX_W-1:0]        out_x,
  output logic [mbet_pkg::PIX_W-1:0]        out_y,
  output logic [mbet_pkg::ITER_W-1:0]       iterations,
  output logic                              inside_res,
  output logic [mbet_pkg::COLOR_W-1:0]      color
);
  import mbet_pkg::*;

  logic [STEP_W-1:0]          pixel_step_r;
  logic [COORD_W-1:0]         origin_real_r;
  logic [COORD_W-1:0]         origin_imag_r;
  logic [ITER_W-1:0]          iter_cap_r;

  logic [PIX_W-1:0]           px_r, py_r;
  logic [ITER_W-1:0]          limit_r, limit_nxt;
  logic signed [COORD_W-1:0]  cr_r, ci_r, zr_r, zi_r;
  logic signed [PROD_W-1:0]   rr_r, ii_r, ri_r;
  logic [ITER_W-1:0]          i_r;
  logic                       inside_r;

  logic [PIX_W-1:0]           out_x_r, out_y_r;
  logic [ITER_W-1:0]          out_iter_r;
  logic                       out_inside_r;
  logic [COLOR_W-1:0]         out_color_r;

  logic [PIX_W+STEP_W-1:0]    prod_x, prod_y;
  logic signed [SAT_W-1:0]    cr_wide, ci_wide, nr_wide, ni_wide;
  logic signed [PROD_W-1:0]   diff;
  logic [PROD_W:0]            mag;
  logic                       escaped;
  logic                       at_limit;
  logic [DIV_NUM_W-1:0]       div_num;
  logic [DIV_NUM_W-1:0]       div_quo;
  logic                       div_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_step_r  <= PIXEL_STEP_RST;
      origin_real_r <= ORIGIN_REAL_RST;
      origin_imag_r <= ORIGIN_IMAG_RST;
      iter_cap_r    <= ITER_CAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PIXEL_STEP:  pixel_step_r  <= cfg_wdata[STEP_W-1:0];
        CFG_ORIGIN_REAL: origin_real_r <= cfg_wdata;
        CFG_ORIGIN_IMAG: origin_imag_r <= cfg_wdata;
        CFG_ITER_CAP:    iter_cap_r    <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // limit: zero counts as one, clamp to the iteration maximum
  always_comb begin
    limit_nxt = iter_cap_r;
    if (iter_cap_r == '0) begin
      limit_nxt = ITER_W'(1);
    end else if (32'(iter_cap_r) > ITER_LIMIT_MAX) begin
      limit_nxt = ITER_W'(ITER_LIMIT_MAX);
    end
  end

  // point in the plane
  assign prod_x  = (PIX_W+STEP_W)'(px_r) * (PIX_W+STEP_W)'(pixel_step_r);
  assign prod_y  = (PIX_W+STEP_W)'(py_r) * (PIX_W+STEP_W)'(pixel_step_r);
  assign cr_wide = $signed({{(SAT_W-PIX_W-STEP_W){1'b0}}, prod_x})
                 + $signed({{(SAT_W-COORD_W){origin_real_r[COORD_W-1]}}, origin_real_r});
  assign ci_wide = $signed({{(SAT_W-PIX_W-STEP_W){1'b0}}, prod_y})
                 + $signed({{(SAT_W-COORD_W){origin_imag_r[COORD_W-1]}}, origin_imag_r});

  // escape test and next z
  assign mag      = {1'b0, rr_r} + {1'b0, ii_r};
  assign escaped  = mag >= ESCAPE_LIMIT;
  assign at_limit = i_r == limit_r;
  assign diff     = rr_r - ii_r;
  assign nr_wide  = SAT_W'(diff >>> FRAC_BITS) + SAT_W'(cr_r);
  assign ni_wide  = SAT_W'(ri_r >>> (FRAC_BITS - 1)) + SAT_W'(ci_r);

  always_comb begin
    sts          = '0;
    sts.stop     = at_limit || escaped;
    sts.in_set   = at_limit;
    sts.div_done = div_done;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      px_r    <= pixel_x;
      py_r    <= pixel_y;
      limit_r <= limit_nxt;
    end
    if (cmd.setup) begin
      cr_r <= sat32(cr_wide);
      ci_r <= sat32(ci_wide);
      zr_r <= '0;
      zi_r <= '0;
      i_r  <= '0;
    end
    if (cmd.mul) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (cmd.upd) begin
      if (sts.stop) begin
        inside_r <= at_limit;
      end else begin
        zr_r <= sat32(nr_wide);
        zi_r <= sat32(ni_wide);
        i_r  <= i_r + 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_x_r      <= px_r;
      out_y_r      <= py_r;
      out_iter_r   <= i_r;
      out_inside_r <= inside_r;
      out_color_r  <= inside_r ? INSIDE_COLOR : {16'h0000, div_quo[7:0]};
    end
  end

  // i*255 = i*256 - i
  assign div_num = {i_r, 8'h00} - DIV_NUM_W'(i_r);

  mbet_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (limit_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign iterations = out_iter_r;
  assign inside_res = out_inside_r;
  assign color      = out_color_r;

endmodule

`default_nettype wire

FILE: hdl/mbet_ctrl.sv
// Controller state machine: sequences setup, iteration, division and result hand-off.
// Depends on mbet_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbet_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  input  wire mbet_pkg::sts_t  sts,
  output mbet_pkg::cmd_t       cmd
);
  import mbet_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_UPD;
      ST_UPD: begin
        if (!sts.stop) begin
          state_nxt = ST_MUL;
        end else if (sts.in_set) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV:   if (sts.div_done) state_nxt = ST_DONE;
      ST_DONE:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_MUL:   cmd.mul   = 1'b1;
      ST_UPD: begin
        cmd.upd       = 1'b1;
        cmd.div_start = sts.stop && !sts.in_set;
      end
      ST_DIV:   ;
      ST_DONE:  cmd.load_out = slot_free;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `MBET_ASSERT_NEXT(a_accept_setup, clk, rst_n, in_tvalid && in_tready, state_r == ST_SETUP)
  `MBET_ASSERT_NEXT(a_mul_then_upd, clk, rst_n, state_r == ST_MUL, state_r == ST_UPD)
  `MBET_ASSERT_NEXT(a_div_waits, clk, rst_n, state_r == ST_DIV && !sts.div_done, state_r == ST_DIV)
  `MBET_ASSERT_NOW(a_start_from_upd, clk, rst_n, cmd.div_start, state_r == ST_UPD && !sts.in_set)

endmodule

`default_nettype wire

FILE: hdl/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time evaluator.
// Depends on mbet_pkg, mbet_ctrl, mbet_dp (which holds mbet_div).
//
//   Channel  Direction  Carries
//   in_      slave      one pixel coordinate per item
//   out_     master     one result per pixel item
//   cfg_     write      pixel_step, origin_real, origin_imag, iteration cap
//
// Sequencing: items are taken one at a time. Each pass of the iteration loop runs
// through the three 32x32 multipliers and then the escape test and update; an
// escaping point then goes through a restoring divider for the grey level, which
// gives one quotient bit a cycle.
// Reset: synchronous, active low; clears control state and loads register reset values.
// Stalls: a finished result waits in the output register while the next item is taken;
// the controller holds a new result until that register is free.
`default_nettype none

module mandelbrot_escape_time_top (
  input  wire                                clk,
  input  wire                                rst_n,
  // configuration write port
  input  wire                                cfg_we,
  input  wire  [mbet_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire  [mbet_pkg::CFG_W-1:0]         cfg_wdata,
  // pixel items
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [23:0]                        in_tdata,   // pixel_x[9:0], pixel_y[19:10], zero pad
  // result items
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [55:0]                        out_tdata,  // out_x[9:0], out_y[19:10],
                                                         // iterations[29:20], color[53:30], pad
  output logic                               out_tuser   // inside_res
);
  import mbet_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic [PIX_W-1:0]   out_x, out_y;
  logic [ITER_W-1:0]  iterations;
  logic               inside_res;
  logic [COLOR_W-1:0] color;

  // sequence one item at a time
  mbet_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // arithmetic, configuration and result registers
  mbet_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pixel_x    (in_tdata[9:0]),
    .pixel_y    (in_tdata[19:10]),
    .cmd        (cmd),
    .sts        (sts),
    .out_x      (out_x),
    .out_y      (out_y),
    .iterations (iterations),
    .inside_res (inside_res),
    .color      (color)
  );

  // pack the result fields, lowest first
  assign out_tdata = {2'b00, color, iterations, out_y, out_x};
  assign out_tuser = inside_res;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the Mandelbrot escape-time evaluator.
// Predicts each pixel result in Q4.28 arithmetic and checks every result item in order.
// Depends on mbet_pkg and mandelbrot_escape_time_top.
`default_nettype none

module tb_top;
  import mbet_pkg::*;

  // Longest quiet stretch: a 1023-iteration pixel plus the divider.
  // The limit allows many times that before giving up.
  localparam int unsigned QUIET_LIMIT = 40000;
  // 4.0 in Q8.56, the escape radius squared
  localparam logic [64:0] ESCAPE_Q856 = 65'h0_0400_0000_0000_0000;

  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [9:0]  iters;
    logic        in_set;
    logic [23:0] color;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_addr = CFG_PIXEL_STEP;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [23:0] in_tdata = '0;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [55:0] out_tdata;
  wire         out_tuser;

  // Shadow copy of the register file, loaded with the reset values
  logic        [30:0] step_q = 31'd1048576;
  logic signed [31:0] org_re = -32'sd536870912;
  logic signed [31:0] org_im = -32'sd402653184;
  logic        [9:0]  iter_lim_q = 10'd64;

  pixel_result_t pending_results[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_seen = 0;
  int unsigned inside_seen = 0;
  int unsigned views_used = 0;
  int unsigned quiet_cycles = 0;

  mandelbrot_escape_time_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  // Clamp to the signed 32-bit range of a Q4.28 value
  function automatic longint clamp_q428(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Escape-time iteration for one pixel under the current register settings
  function automatic pixel_result_t predict_escape(input logic [9:0] px, input logic [9:0] py);
    pixel_result_t r;
    longint        cr, ci, zr, zi, rr, ii, ri;
    int unsigned   lim, n;
    logic [64:0]   mag;
    lim = 32'(iter_lim_q);
    if (lim == 0) lim = 1;
    if (lim > ITER_LIMIT_MAX) lim = ITER_LIMIT_MAX;
    cr = clamp_q428(longint'(px) * longint'(step_q) + longint'(org_re));
    ci = clamp_q428(longint'(py) * longint'(step_q) + longint'(org_im));
    zr = 0;
    zi = 0;
    n = 0;
    mag = '0;
    while (n < lim && mag < ESCAPE_Q856) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      // arithmetic shift on a signed value rounds toward minus infinity
      zr = clamp_q428(((rr - ii) >>> FRAC_BITS) + cr);
      zi = clamp_q428((ri >>> (FRAC_BITS - 1)) + ci);
      n++;
      mag = {1'b0, zr * zr} + {1'b0, zi * zi};
    end
    r.x = px;
    r.y = py;
    r.iters = n[9:0];
    r.in_set = (n == lim);
    r.color = r.in_set ? INSIDE_COLOR : 24'((n * 255) / lim);
    return r;
  endfunction

  // Present one pixel item, with an optional random gap first; hold valid across
  // back-to-back items rather than dropping and raising it in one step.
  task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, py, px};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_escape(px, py));
    pixels_sent++;
  endtask

  // Drop valid, let every outstanding result drain, then a short settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_PIXEL_STEP:  step_q = val[30:0];
      CFG_ORIGIN_REAL: org_re = val;
      CFG_ORIGIN_IMAG: org_im = val;
      CFG_ITER_CAP:    iter_lim_q = val[9:0];
      default: ;
    endcase
  endtask

  // Load a complete view of the plane once the block has gone idle
  task automatic program_view(input logic [31:0] step, input logic [31:0] re,
                              input logic [31:0] im, input logic [31:0] lim);
    wait_idle();
    write_reg(CFG_PIXEL_STEP, step);
    write_reg(CFG_ORIGIN_REAL, re);
    write_reg(CFG_ORIGIN_IMAG, im);
    write_reg(CFG_ITER_CAP, lim);
    views_used++;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default: begin send_idle_pct = 11; recv_stall_pct = 11; end
    endcase
  endtask

  // Image corners and a couple of interior points under the reset view
  task automatic test_reset_defaults();
    set_idling(0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd512, 10'd384);
    send_pixel(10'd341, 10'd682);
  endtask

  // Zero limit acts as one, then the smallest and largest limits
  task automatic test_iteration_limits();
    set_idling(3);
    program_view(32'd1048576, 32'd0, 32'd0, 32'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    program_view(32'd1048576, 32'd0, 32'd0, 32'd1);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd700, 10'd20);
    // c = 0 stays put for the full limit; the others exercise the divider at 1023
    program_view(32'd1048576, 32'd0, 32'd0, 32'd1023);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd600, 10'd0);
    send_pixel(10'd300, 10'd300);
  endtask

  // A zero step pins every pixel to the origin
  task automatic test_zero_step();
    set_idling(1);
    program_view(32'd0, 32'h8000_0000, 32'h8000_0000, 32'd20);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd5, 10'd700);
    program_view(32'd0, 32'd67108864, 32'd0, 32'd20);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
  endtask

  // Largest step and extreme origins drive the coordinates past the Q4.28 range.
  // Bit 31 of the step write must be dropped.
  task automatic test_coordinate_saturation();
    set_idling(2);
    program_view(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
  endtask

  // Random views: mostly aimed at the set with varied zoom, some pure noise;
  // limits mostly modest so inside points stay cheap, a few near the top.
  task automatic test_random_views();
    int unsigned phase, k, n_items, lim;
    logic [31:0] step, re, im;
    for (phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       lim = $urandom_range(200, 1023);
        1:       lim = $urandom_range(0, 3);
        default: lim = $urandom_range(4, 96);
      endcase
      if ($urandom_range(0, 7) == 0) begin
        step = $urandom;
        re   = $urandom;
        im   = $urandom;
      end else begin
        step = $urandom_range(32'd4096, 32'd2097152);
        re   = 32'(-671088640 + int'($urandom_range(0, 32'd536870912)));
        im   = 32'(-402653184 + int'($urandom_range(0, 32'd268435456)));
      end
      program_view(step, re, im, lim);
      set_idling(phase);
      n_items = (lim > 200) ? 8 : 46;
      for (k = 0; k < n_items; k++) begin
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      end
    end
  endtask

  // Receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    pixel_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x      = out_tdata[9:0];
      got.y      = out_tdata[19:10];
      got.iters  = out_tdata[29:20];
      got.color  = out_tdata[53:30];
      got.in_set = out_tuser;
      results_seen++;
      if (got.in_set) inside_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: x=%0d y=%0d iters=%0d inside=%0b color=%h",
                   got.x, got.y, got.iters, got.in_set, got.color);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.iters !== want.iters ||
            got.in_set !== want.in_set || got.color !== want.color) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected x=%0d y=%0d iters=%0d inside=%0b color=%h",
                     want.x, want.y, want.iters, want.in_set, want.color);
            $display("          actual   x=%0d y=%0d iters=%0d inside=%0b color=%h",
                     got.x, got.y, got.iters, got.in_set, got.color);
          end
        end
      end
    end
  end

  // Watchdog: end the run if no item moves on either channel for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // Hold reset at the start, then release it for good
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_iteration_limits();
    test_zero_step();
    test_coordinate_saturation();
    test_random_views();

    // Drain, then leave room for any stray result to show up
    wait_idle();
    repeat (64) @(posedge clk);

    $display("Run covered %0d pixel items across %0d register views under four idling modes.",
             pixels_sent, views_used);
    $display("Checked %0d results, %0d of them inside the set; %0d mismatches, %0d left over.",
             results_seen, inside_seen, mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/mbet_pkg.sv
hdl/mbet_div.sv
hdl/mbet_dp.sv
hdl/mbet_ctrl.sv
hdl/mandelbrot_escape_time_top.sv
bench/tb_top.sv
